FILE: rtl/impq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package impq_pkg;

  // Sizes of the heap storage.
  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DIST_W   = 31;
  localparam int VTX_W    = 16;
  localparam int REQ_DW   = 32;

  // Operation codes.
  typedef enum logic [1:0] {
    FN_INSERT   = 2'd0,
    FN_DECREASE = 2'd1,
    FN_EXTRACT  = 2'd2,
    FN_CONTAINS = 2'd3
  } op_t;

  // Status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_NEG    = 3'd2,
    ST_FULL   = 3'd3,
    ST_ABSENT = 3'd4,
    ST_EMPTY  = 3'd5
  } st_t;

  // Request and response payloads.
  typedef struct packed {
    logic [1:0]               func;
    logic [VTX_W-1:0]         vertex;
    logic signed [REQ_DW-1:0] dist_req;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VTX_W-1:0] min_vertex;
    logic             found;
    logic             heap_empty;
  } rsp_t;

  // One heap entry as held in memory.
  typedef struct packed {
    logic [SLOT_W-1:0] vtx;
    logic [DIST_W-1:0] key;
  } ent_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DK_POS,
    S_DK_ENT,
    S_EX_ROOT,
    S_EX_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FIN
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;
    logic dk_pos;
    logic dk_ent;
    logic ex_root;
    logic ex_last;
    logic up_rd;
    logic up_cmp;
    logic dn_rdl;
    logic dn_rdr;
    logic dn_cmp;
    logic fin;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] func;
    logic       quick;
    logic       slot_zero;
    logic       parent_gt;
    logic       left_in;
    logic       move;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/indexed_min_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Contains and every refused request: result in the cycle after the transfer; busy stays low.
// Insert and decrease key: the entry rises level by level, reading the parent, then comparing.
// Extract min: root and last entry are read, then the entry sinks level by level (read left, read right, compare).
// The entry memory's single read port sets the per-level cost; one item is worked at a time.
// Synchronous reset empties the heap, clears all presence flags and sets capacity to 256.

module indexed_min_priority_queue_top import impq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req,
  output logic                  done,
  output rsp_t                  res,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // Controller.
  impq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath with heap storage.
  impq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: rtl/impq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module impq_ctrl import impq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !sts.quick) begin
          case (sts.func)
            FN_INSERT:   state_next = S_UP_RD;
            FN_DECREASE: state_next = S_DK_POS;
            FN_EXTRACT:  state_next = S_EX_ROOT;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_DK_POS:  state_next = S_DK_ENT;
      S_DK_ENT:  state_next = S_UP_RD;
      S_EX_ROOT: state_next = S_EX_LAST;
      S_EX_LAST: state_next = S_DN_RDL;
      S_UP_RD:   state_next = sts.slot_zero ? S_FIN : S_UP_CMP;
      S_UP_CMP:  state_next = sts.parent_gt ? S_UP_RD : S_FIN;
      S_DN_RDL:  state_next = sts.left_in ? S_DN_RDR : S_FIN;
      S_DN_RDR:  state_next = S_DN_CMP;
      S_DN_CMP:  state_next = sts.move ? S_DN_RDL : S_FIN;
      S_FIN:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.accept  = start;
      S_DK_POS:  cmd.dk_pos  = 1'b1;
      S_DK_ENT:  cmd.dk_ent  = 1'b1;
      S_EX_ROOT: cmd.ex_root = 1'b1;
      S_EX_LAST: cmd.ex_last = 1'b1;
      S_UP_RD:   cmd.up_rd   = 1'b1;
      S_UP_CMP:  cmd.up_cmp  = 1'b1;
      S_DN_RDL:  cmd.dn_rdl  = 1'b1;
      S_DN_RDR:  cmd.dn_rdr  = 1'b1;
      S_DN_CMP:  cmd.dn_cmp  = 1'b1;
      S_FIN:     cmd.fin     = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/impq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module impq_dp import impq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire req_t             req,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  output logic                  done,
  output rsp_t                  res
);

  // Storage: heap entries, vertex positions and presence flags.
  ent_t              ent_mem [CAPACITY];
  logic [SLOT_W-1:0] pos_mem [CAPACITY];
  logic [CAPACITY-1:0] present;

  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  count;
  logic [1:0]        func_q;
  logic [DIST_W-1:0] dreq_q;
  logic [SLOT_W-1:0] cur_v;
  logic [DIST_W-1:0] cur_d;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] root_v;
  logic              swapped;
  logic              same_v;
  ent_t              left_q;
  ent_t              ent_rdata;
  logic [SLOT_W-1:0] pos_rdata;

  logic [CNT_W-1:0]  eff_cap;
  logic [SLOT_W-1:0] v_lo;
  logic              in_range;
  logic [2:0]        acc_status;
  logic [SLOT_W-1:0] parent;
  logic [CNT_W:0]    left_idx;
  logic [CNT_W:0]    right_idx;
  logic              left_in;
  logic              right_in;
  logic              l_better;
  logic              r_better;
  logic [DIST_W-1:0] best_d;
  logic              parent_gt;
  logic              do_swap;
  ent_t              mv;
  logic [SLOT_W-1:0] mv_slot;
  logic [SLOT_W-1:0] ent_raddr;
  logic              is_ext;
  logic              fin_pres;

  // Request checks at acceptance.
  always_comb begin
    eff_cap  = (cap > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cap;
    v_lo     = req.vertex[SLOT_W-1:0];
    in_range = req.vertex < VTX_W'(eff_cap);
    acc_status = ST_OK;
    case (req.func)
      FN_INSERT: begin
        if (!in_range) acc_status = ST_RANGE;
        else if (req.dist_req[REQ_DW-1]) acc_status = ST_NEG;
        else if (count >= eff_cap) acc_status = ST_FULL;
      end
      FN_DECREASE: begin
        if (!in_range) acc_status = ST_RANGE;
        else if (!present[v_lo]) acc_status = ST_ABSENT;
        else if (req.dist_req[REQ_DW-1]) acc_status = ST_NEG;
      end
      FN_EXTRACT: begin
        if (count == '0) acc_status = ST_EMPTY;
      end
      default: begin
        if (!in_range) acc_status = ST_RANGE;
      end
    endcase
  end

  // Sift compares: parent for rising, both children for sinking.
  always_comb begin
    parent    = (slot - SLOT_W'(1)) >> 1;
    left_idx  = {1'b0, slot, 1'b1};
    right_idx = left_idx + (CNT_W+1)'(1);
    left_in   = left_idx < {1'b0, count};
    right_in  = right_idx < {1'b0, count};
    parent_gt = ent_rdata.key > cur_d;
    l_better  = left_in && (left_q.key < cur_d);
    best_d    = l_better ? left_q.key : cur_d;
    r_better  = right_in && (ent_rdata.key < best_d);
    if (cmd.up_cmp) begin
      mv      = ent_rdata;
      mv_slot = parent;
      do_swap = parent_gt;
    end else begin
      mv      = r_better ? ent_rdata : left_q;
      mv_slot = r_better ? right_idx[SLOT_W-1:0] : left_idx[SLOT_W-1:0];
      do_swap = cmd.dn_cmp && (l_better || r_better);
    end
    is_ext   = (func_q == FN_EXTRACT);
    fin_pres = swapped || !is_ext || (cur_v != root_v);
  end

  // Entry read address.
  always_comb begin
    ent_raddr = '0;
    if (cmd.dk_pos) ent_raddr = pos_rdata;
    else if (cmd.ex_root) ent_raddr = SLOT_W'(count - CNT_W'(1));
    else if (cmd.up_rd) ent_raddr = parent;
    else if (cmd.dn_rdl) ent_raddr = left_idx[SLOT_W-1:0];
    else if (cmd.dn_rdr) ent_raddr = right_idx[SLOT_W-1:0];
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (do_swap) begin
      ent_mem[slot] <= mv;
    end else if (cmd.fin) begin
      ent_mem[slot] <= '{vtx: cur_v, key: cur_d};
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  // Position memory: the read serves decrease key.
  always_ff @(posedge clk) begin
    if (do_swap) begin
      pos_mem[mv.vtx] <= slot;
    end else if (cmd.fin && !(swapped && same_v)) begin
      pos_mem[cur_v] <= slot;
    end
    pos_rdata <= pos_mem[v_lo];
  end

  // Presence flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (cmd.ex_root) begin
      present[ent_rdata.vtx] <= 1'b0;
    end else if (do_swap) begin
      present[mv.vtx] <= 1'b1;
    end else if (cmd.fin && !(swapped && same_v)) begin
      present[cur_v] <= fin_pres;
    end
  end

  // Capacity register and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CNT_W'(CAPACITY);
      count <= '0;
    end else begin
      if (cfg_we) cap <= cfg_wdata;
      if (cmd.accept && acc_status == ST_OK && req.func == FN_INSERT) begin
        count <= count + CNT_W'(1);
      end else if (cmd.ex_last) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Working registers of the sift.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= req.func;
      dreq_q  <= req.dist_req[DIST_W-1:0];
      swapped <= 1'b0;
      same_v  <= 1'b0;
      slot    <= count[SLOT_W-1:0];
      cur_v   <= v_lo;
      cur_d   <= req.dist_req[DIST_W-1:0];
    end
    if (cmd.dk_pos) slot <= pos_rdata;
    if (cmd.dk_ent) begin
      cur_v <= ent_rdata.vtx;
      cur_d <= dreq_q;
    end
    if (cmd.ex_root) root_v <= ent_rdata.vtx;
    if (cmd.ex_last) begin
      cur_v <= ent_rdata.vtx;
      cur_d <= ent_rdata.key;
      slot  <= '0;
    end
    if (cmd.dn_rdr) left_q <= ent_rdata;
    if (do_swap) begin
      slot    <= mv_slot;
      swapped <= 1'b1;
      same_v  <= (mv.vtx == cur_v);
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.accept && sts.quick) || cmd.fin;
    end
    if (cmd.fin) begin
      res.status     <= ST_OK;
      res.min_vertex <= is_ext ? VTX_W'(root_v) : '0;
      res.found      <= 1'b0;
      res.heap_empty <= (count == '0);
    end else if (cmd.accept) begin
      res.status     <= acc_status;
      res.min_vertex <= '0;
      res.found      <= (req.func == FN_CONTAINS) && (acc_status == ST_OK) && present[v_lo];
      res.heap_empty <= (count == '0);
    end
  end

  // Status to the controller.
  always_comb begin
    sts.func      = req.func;
    sts.quick     = (acc_status != ST_OK) || (req.func == FN_CONTAINS);
    sts.slot_zero = (slot == '0);
    sts.parent_gt = parent_gt;
    sts.left_in   = left_in;
    sts.move      = l_better || r_better;
  end

endmodule

`default_nettype wire

FILE: rtl/impq_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module impq_chk import impq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t res
);

  // A transfer either answers at once or starts a sift.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("transfer neither answered nor started work");

  // Finishing a sift always shows a result.
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("work finished without a result");

  // A refused request carries no vertex and no found flag.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_OK) |-> (res.min_vertex == '0 && !res.found))
    else $error("error result carries data");

  // Extract on an empty heap reports an empty heap.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_EMPTY) |-> res.heap_empty)
    else $error("empty status without empty flag");

endmodule

bind indexed_min_priority_queue_top impq_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);

`default_nettype wire
